### src/rurr_pkg.sv
// Package for the reliable UDP receive reorder unit: transaction types, codes and helpers.
// No dependencies; used by the top level, rurr_out and the testbench.
package rurr_pkg;

   localparam int SEQ_W  = 15;
   localparam int LEN_W  = 10;
   localparam int SLOT_W = 10;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD = 10'd1010;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_PKT  = 2'd1;
   localparam logic [1:0] OP_OPEN = 2'd2;

   localparam logic [2:0] T_NONE   = 3'd0;
   localparam logic [2:0] T_DATA   = 3'd1;
   localparam logic [2:0] T_SYN    = 3'd2;
   localparam logic [2:0] T_ACK    = 3'd3;
   localparam logic [2:0] T_FIN    = 3'd4;
   localparam logic [2:0] T_SYNACK = 3'd5;

   localparam logic [1:0] KIND_SEND    = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_CLOSED  = 2'd2;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_SYN  = 3'd1;
   localparam logic [2:0] PH_NAME = 3'd2;
   localparam logic [2:0] PH_CONN = 3'd3;
   localparam logic [2:0] PH_WAIT = 3'd4;

   localparam logic [1:0] CSR_INITIAL_SEQ     = 2'd0;
   localparam logic [1:0] CSR_NAME_LENGTH     = 2'd1;
   localparam logic [1:0] CSR_TIME_WAIT_TICKS = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [2:0]        pkt_type;
      logic [SEQ_W-1:0]  pkt_seq;
      logic [SEQ_W-1:0]  pkt_next_seq;
      logic [LEN_W-1:0]  pkt_length;
      logic [SLOT_W-1:0] payload_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]        out_kind;
      logic [2:0]        send_type;
      logic [SEQ_W-1:0]  send_seq;
      logic [LEN_W-1:0]  send_length;
      logic [SLOT_W-1:0] deliver_slot;
      logic [LEN_W-1:0]  deliver_length;
      logic              overflow;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [SEQ_W-1:0]  nxt;
      logic [LEN_W-1:0]  len;
      logic [SLOT_W-1:0] slot;
   } held_entry_type;

   typedef struct packed {
      logic    push;
      logic    finish;
      rsp_type data;
   } emit_type;

   function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
      return (v > MAX_PAYLOAD) ? MAX_PAYLOAD : v;
   endfunction

   function automatic rsp_type make_send(input logic [2:0] t, input logic [SEQ_W-1:0] s,
                                         input logic [LEN_W-1:0] l);
      rsp_type r;
      r = '0;
      r.out_kind    = KIND_SEND;
      r.send_type   = t;
      r.send_seq    = s;
      r.send_length = l;
      return r;
   endfunction

   function automatic rsp_type make_deliver(input logic [SLOT_W-1:0] s,
                                            input logic [LEN_W-1:0] l);
      rsp_type r;
      r = '0;
      r.out_kind       = KIND_DELIVER;
      r.deliver_slot   = s;
      r.deliver_length = l;
      return r;
   endfunction

endpackage

### src/reliable_udp_receive_reorder_unit.sv
// Top level of the reliable UDP receive reorder unit: sequencer and stores; needs rurr_pkg,
// rurr_ram and rurr_out. A control transaction pushes at most one result and finishes via S_DONE.
// A data packet searches the history, scans the held entries and moves entries down on removal,
// and halves the history when it fills. One transaction at a time: busy drops in the same cycle
// that rurr_out strobes the last result. Results strobe rsp_valid one cycle each; synchronous
// active-high reset clears state and counts.
module reliable_udp_receive_reorder_unit
   import rurr_pkg::*;
#(
   parameter int REORDER_DEPTH = 32,
   parameter int HISTORY_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int RAW  = $clog2(REORDER_DEPTH);
   localparam int RCW  = $clog2(REORDER_DEPTH + 1);
   localparam int HAW  = $clog2(HISTORY_DEPTH);
   localparam int HCW  = $clog2(HISTORY_DEPTH + 1);
   localparam int HALF = HISTORY_DEPTH / 2;
   localparam int OFFS = HISTORY_DEPTH - HALF;
   localparam int HEW  = $bits(held_entry_type);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_HRD      = 4'd1;
   localparam logic [3:0] S_HCMP     = 4'd2;
   localparam logic [3:0] S_DEC      = 4'd3;
   localparam logic [3:0] S_SRD      = 4'd4;
   localparam logic [3:0] S_SCMP     = 4'd5;
   localparam logic [3:0] S_SHIFT_RD = 4'd6;
   localparam logic [3:0] S_SHIFT_WR = 4'd7;
   localparam logic [3:0] S_ACK      = 4'd8;
   localparam logic [3:0] S_HALF_RD  = 4'd9;
   localparam logic [3:0] S_HALF_WR  = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0]        state_ff, state_in;
   logic [SEQ_W-1:0]  init_seq_ff, init_seq_in;
   logic [LEN_W-1:0]  name_len_ff, name_len_in;
   logic [3:0]        twt_ff, twt_in;
   logic [2:0]        phase_ff, phase_in;
   logic [SEQ_W-1:0]  first_ff, first_in;
   logic [SEQ_W-1:0]  exp_ff, exp_in;
   logic              await_ff, await_in;
   logic [SEQ_W-1:0]  fin_ff, fin_in;
   logic [3:0]        wc_ff, wc_in;
   logic [RCW-1:0]    held_cnt_ff, held_cnt_in;
   logic [HCW-1:0]    ack_cnt_ff, ack_cnt_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [SEQ_W-1:0]  nxt_ff, nxt_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              dup_ff, dup_in;
   logic [HAW-1:0]    hidx_ff, hidx_in;
   logic [RAW-1:0]    sidx_ff, sidx_in;
   logic [RAW-1:0]    sj_ff, sj_in;

   logic              held_we;
   logic [RAW-1:0]    held_wa, held_ra;
   logic [HEW-1:0]    held_wd, held_rd;
   held_entry_type    held_rec, ins_rec;
   logic              hist_we;
   logic [HAW-1:0]    hist_wa, hist_ra;
   logic [SEQ_W-1:0]  hist_wd, hist_rd;
   emit_type          emit;
   logic              in_order;

   assign busy     = (state_ff != S_IDLE);
   assign held_rec = held_entry_type'(held_rd);
   assign in_order = (await_ff && (seq_ff == first_ff)) || (!await_ff && (seq_ff == exp_ff));

   always_comb begin
      ins_rec      = '0;
      ins_rec.seq  = seq_ff;
      ins_rec.nxt  = nxt_ff;
      ins_rec.len  = len_ff;
      ins_rec.slot = slot_ff;
   end

   always_comb begin
      state_in    = state_ff;
      init_seq_in = init_seq_ff;
      name_len_in = name_len_ff;
      twt_in      = twt_ff;
      phase_in    = phase_ff;
      first_in    = first_ff;
      exp_in      = exp_ff;
      await_in    = await_ff;
      fin_in      = fin_ff;
      wc_in       = wc_ff;
      held_cnt_in = held_cnt_ff;
      ack_cnt_in  = ack_cnt_ff;
      seq_in      = seq_ff;
      nxt_in      = nxt_ff;
      len_in      = len_ff;
      slot_in     = slot_ff;
      dup_in      = dup_ff;
      hidx_in     = hidx_ff;
      sidx_in     = sidx_ff;
      sj_in       = sj_ff;
      emit        = '0;
      held_we     = 1'b0;
      held_wa     = sj_ff;
      held_wd     = held_rd;
      held_ra     = (state_ff == S_SHIFT_RD) ? (sj_ff + 1'b1) : sidx_ff;
      hist_we     = 1'b0;
      hist_wa     = hidx_ff;
      hist_wd     = hist_rd;
      hist_ra     = (state_ff == S_HALF_RD) ? (HAW'(OFFS) + hidx_ff) : hidx_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_INITIAL_SEQ:     init_seq_in = csr_wdata;
            CSR_NAME_LENGTH:     name_len_in = csr_wdata[LEN_W-1:0];
            CSR_TIME_WAIT_TICKS: twt_in = csr_wdata[3:0];
            default:             ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               seq_in  = req_data.pkt_seq;
               nxt_in  = req_data.pkt_next_seq;
               len_in  = sat_len(req_data.pkt_length);
               slot_in = req_data.payload_slot;
               dup_in  = 1'b0;
               hidx_in = '0;
               case (req_data.op)
                  OP_OPEN: begin
                     if (phase_ff == PH_IDLE) begin
                        first_in    = '0;
                        exp_in      = '0;
                        await_in    = 1'b1;
                        fin_in      = '0;
                        wc_in       = '0;
                        held_cnt_in = '0;
                        ack_cnt_in  = '0;
                        phase_in    = PH_SYN;
                        emit.push   = 1'b1;
                        emit.data   = make_send(T_SYN, init_seq_ff, '0);
                        state_in    = S_DONE;
                     end
                  end
                  OP_TICK: begin
                     if (phase_ff == PH_SYN) begin
                        emit.push = 1'b1;
                        emit.data = make_send(T_SYN, init_seq_ff, '0);
                        state_in  = S_DONE;
                     end else if (phase_ff == PH_NAME) begin
                        emit.push = 1'b1;
                        emit.data = make_send(T_ACK, first_ff, sat_len(name_len_ff));
                        state_in  = S_DONE;
                     end else if (phase_ff == PH_WAIT) begin
                        if (wc_ff <= 4'd1) begin
                           wc_in              = '0;
                           phase_in           = PH_IDLE;
                           emit.push          = 1'b1;
                           emit.data          = '0;
                           emit.data.out_kind = KIND_CLOSED;
                           state_in           = S_DONE;
                        end else begin
                           wc_in = wc_ff - 4'd1;
                        end
                     end
                  end
                  OP_PKT: begin
                     case (phase_ff)
                        PH_SYN: begin
                           if (req_data.pkt_type == T_SYNACK) begin
                              first_in  = req_data.pkt_seq;
                              phase_in  = PH_NAME;
                              emit.push = 1'b1;
                              emit.data = make_send(T_ACK, req_data.pkt_seq,
                                                    sat_len(name_len_ff));
                              state_in  = S_DONE;
                           end
                        end
                        PH_NAME: begin
                           if (req_data.pkt_type == T_DATA) begin
                              phase_in = PH_CONN;
                              state_in = (ack_cnt_ff == '0) ? S_DEC : S_HRD;
                           end else begin
                              state_in = S_ACK;
                           end
                        end
                        PH_CONN: begin
                           if (req_data.pkt_type == T_FIN) begin
                              fin_in    = req_data.pkt_seq;
                              wc_in     = twt_ff;
                              phase_in  = PH_WAIT;
                              emit.push = 1'b1;
                              emit.data = make_send(T_FIN, req_data.pkt_seq, '0);
                              state_in  = S_DONE;
                           end else if (req_data.pkt_type == T_DATA) begin
                              state_in = (ack_cnt_ff == '0) ? S_DEC : S_HRD;
                           end
                        end
                        PH_WAIT: begin
                           emit.push = 1'b1;
                           emit.data = make_send(T_FIN, fin_ff, '0);
                           state_in  = S_DONE;
                        end
                        default: ;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         S_HRD: begin
            state_in = S_HCMP;
         end
         S_HCMP: begin
            if (hist_rd == seq_ff) begin
               dup_in = 1'b1;
            end
            if ((HCW'(hidx_ff) + 1'b1) < ack_cnt_ff) begin
               hidx_in  = hidx_ff + 1'b1;
               state_in = S_HRD;
            end else begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            sidx_in = '0;
            if (dup_ff) begin
               state_in = S_ACK;
            end else if (in_order) begin
               emit.push = 1'b1;
               emit.data = make_deliver(slot_ff, len_ff);
               exp_in    = nxt_ff;
               await_in  = 1'b0;
               state_in  = (held_cnt_ff != '0) ? S_SRD : S_ACK;
            end else if (held_cnt_ff >= RCW'(REORDER_DEPTH)) begin
               emit.push          = 1'b1;
               emit.data          = '0;
               emit.data.out_kind = KIND_SEND;
               emit.data.overflow = 1'b1;
               state_in           = S_DONE;
            end else begin
               held_we     = 1'b1;
               held_wa     = held_cnt_ff[RAW-1:0];
               held_wd     = HEW'(ins_rec);
               held_cnt_in = held_cnt_ff + 1'b1;
               state_in    = S_ACK;
            end
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (held_rec.seq == exp_ff) begin
               emit.push = 1'b1;
               emit.data = make_deliver(held_rec.slot, held_rec.len);
               exp_in    = held_rec.nxt;
               if ((RCW'(sidx_ff) + 1'b1) < held_cnt_ff) begin
                  sj_in    = sidx_ff;
                  state_in = S_SHIFT_RD;
               end else begin
                  held_cnt_in = held_cnt_ff - 1'b1;
                  sidx_in     = '0;
                  state_in    = (held_cnt_ff != RCW'(1)) ? S_SRD : S_ACK;
               end
            end else if ((RCW'(sidx_ff) + 1'b1) < held_cnt_ff) begin
               sidx_in  = sidx_ff + 1'b1;
               state_in = S_SRD;
            end else begin
               state_in = S_ACK;
            end
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            held_we = 1'b1;
            held_wa = sj_ff;
            held_wd = held_rd;
            if ((RCW'(sj_ff) + RCW'(2)) < held_cnt_ff) begin
               sj_in    = sj_ff + 1'b1;
               state_in = S_SHIFT_RD;
            end else begin
               held_cnt_in = held_cnt_ff - 1'b1;
               sidx_in     = '0;
               state_in    = (held_cnt_ff != RCW'(1)) ? S_SRD : S_ACK;
            end
         end
         S_ACK: begin
            emit.push  = 1'b1;
            emit.data  = make_send(T_ACK, seq_ff, '0);
            hist_we    = 1'b1;
            hist_wa    = ack_cnt_ff[HAW-1:0];
            hist_wd    = seq_ff;
            ack_cnt_in = ack_cnt_ff + 1'b1;
            hidx_in    = '0;
            state_in   = (ack_cnt_ff == HCW'(HISTORY_DEPTH - 1)) ? S_HALF_RD : S_DONE;
         end
         S_HALF_RD: begin
            state_in = S_HALF_WR;
         end
         S_HALF_WR: begin
            hist_we = 1'b1;
            hist_wa = hidx_ff;
            hist_wd = hist_rd;
            if ((HCW'(hidx_ff) + 1'b1) < HCW'(HALF)) begin
               hidx_in  = hidx_ff + 1'b1;
               state_in = S_HALF_RD;
            end else begin
               ack_cnt_in = HCW'(HALF);
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            emit.finish = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         init_seq_ff <= '0;
         name_len_ff <= '0;
         twt_ff      <= 4'd2;
         phase_ff    <= PH_IDLE;
         first_ff    <= '0;
         exp_ff      <= '0;
         await_ff    <= 1'b1;
         fin_ff      <= '0;
         wc_ff       <= '0;
         held_cnt_ff <= '0;
         ack_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         init_seq_ff <= init_seq_in;
         name_len_ff <= name_len_in;
         twt_ff      <= twt_in;
         phase_ff    <= phase_in;
         first_ff    <= first_in;
         exp_ff      <= exp_in;
         await_ff    <= await_in;
         fin_ff      <= fin_in;
         wc_ff       <= wc_in;
         held_cnt_ff <= held_cnt_in;
         ack_cnt_ff  <= ack_cnt_in;
      end
      seq_ff  <= seq_in;
      nxt_ff  <= nxt_in;
      len_ff  <= len_in;
      slot_ff <= slot_in;
      dup_ff  <= dup_in;
      hidx_ff <= hidx_in;
      sidx_ff <= sidx_in;
      sj_ff   <= sj_in;
   end

   rurr_ram #(.WIDTH(HEW), .DEPTH(REORDER_DEPTH)) u_held_ram (
      .clock (clock),
      .we    (held_we),
      .waddr (held_wa),
      .wdata (held_wd),
      .raddr (held_ra),
      .rdata (held_rd)
   );

   rurr_ram #(.WIDTH(SEQ_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_wa),
      .wdata (hist_wd),
      .raddr (hist_ra),
      .rdata (hist_rd)
   );

   rurr_out u_out (
      .clock     (clock),
      .reset     (reset),
      .emit      (emit),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff <= RCW'(REORDER_DEPTH))
      else $error("Reorder store count exceeds its depth.");

   a_hist_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (ack_cnt_ff < HCW'(HISTORY_DEPTH)))
      else $error("History count not below its depth between transactions.");

   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |-> rsp_data.last)
      else $error("Overflow report is not the only result of its transaction.");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> !busy)
      else $error("Sequencer did not return to idle after finishing.");

endmodule

### src/rurr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rurr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/rurr_out.sv
// Result staging: holds one result back so that the final one of a transaction carries last.
// Depends on rurr_pkg.
module rurr_out
   import rurr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  emit_type emit,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;
   logic    valid_ff, valid_in;
   rsp_type out_ff, out_in;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      valid_in      = 1'b0;
      out_in        = out_ff;
      if (emit.push) begin
         if (pend_valid_ff) begin
            valid_in    = 1'b1;
            out_in      = pend_ff;
            out_in.last = 1'b0;
         end
         pend_in       = emit.data;
         pend_valid_in = 1'b1;
      end else if (emit.finish && pend_valid_ff) begin
         valid_in      = 1'b1;
         out_in        = pend_ff;
         out_in.last   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         valid_ff      <= valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for reliable_udp_receive_reorder_unit: connection sessions with
// reordered, duplicated and overflowing data are driven and every result is predicted.
// Depends on rurr_pkg and the unit's RTL.
module testbench;
   import rurr_pkg::*;

   class rx_scoreboard;
      rsp_type        pending[$];
      int             errors;
      logic [14:0]    init_seq;
      logic [9:0]     name_len;
      logic [3:0]     wait_ticks;
      logic [2:0]     phase;
      logic [14:0]    first_seq, exp_seq, fin_seq;
      logic           awaiting_first;
      logic [3:0]     wait_count;
      held_entry_type held[32];
      int             held_n;
      logic [14:0]    history[16];
      int             history_n;

      function new();
         errors = 0;
         init_seq = '0;
         name_len = '0;
         wait_ticks = 4'd2;
         phase = PH_IDLE;
         first_seq = '0;
         exp_seq = '0;
         fin_seq = '0;
         awaiting_first = 1'b1;
         wait_count = '0;
         held_n = 0;
         history_n = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [14:0] val);
         case (idx)
            CSR_INITIAL_SEQ:     init_seq = val;
            CSR_NAME_LENGTH:     name_len = val[9:0];
            CSR_TIME_WAIT_TICKS: wait_ticks = val[3:0];
            default: ;
         endcase
      endfunction

      function logic [9:0] clip(logic [9:0] v);
         return (v > MAX_PAYLOAD) ? MAX_PAYLOAD : v;
      endfunction

      function void add_send(logic [2:0] t, logic [14:0] s, logic [9:0] l);
         rsp_type r;
         r = '0;
         r.out_kind = KIND_SEND;
         r.send_type = t;
         r.send_seq = s;
         r.send_length = l;
         pending.push_back(r);
      endfunction

      function void add_deliver(logic [9:0] s, logic [9:0] l);
         rsp_type r;
         r = '0;
         r.out_kind = KIND_DELIVER;
         r.deliver_slot = s;
         r.deliver_length = l;
         pending.push_back(r);
      endfunction

      function void acknowledge(logic [14:0] s);
         add_send(T_ACK, s, '0);
         history[history_n] = s;
         history_n++;
         if (history_n >= 16) begin
            for (int i = 0; i < 8; i++) history[i] = history[8 + i];
            history_n = 8;
         end
      endfunction

      function void accept_data(req_type r);
         bit      dup;
         int      i;
         rsp_type o;
         dup = 0;
         for (i = 0; i < history_n; i++) if (history[i] == r.pkt_seq) dup = 1;
         if (!dup) begin
            if ((awaiting_first && r.pkt_seq == first_seq) ||
                (!awaiting_first && r.pkt_seq == exp_seq)) begin
               add_deliver(r.payload_slot, clip(r.pkt_length));
               exp_seq = r.pkt_next_seq;
               awaiting_first = 0;
               i = 0;
               while (i < held_n) begin
                  if (held[i].seq == exp_seq) begin
                     add_deliver(held[i].slot, held[i].len);
                     exp_seq = held[i].nxt;
                     for (int j = i; j < held_n - 1; j++) held[j] = held[j + 1];
                     held_n--;
                     i = 0;
                  end else begin
                     i++;
                  end
               end
            end else if (held_n >= 32) begin
               o = '0;
               o.overflow = 1'b1;
               pending.push_back(o);
               return;
            end else begin
               held[held_n] = '{r.pkt_seq, r.pkt_next_seq, clip(r.pkt_length), r.payload_slot};
               held_n++;
            end
         end
         acknowledge(r.pkt_seq);
      endfunction

      function void note_request(req_type r);
         int prior_size;
         prior_size = pending.size();
         case (r.op)
            OP_OPEN: if (phase == PH_IDLE) begin
               first_seq = '0;
               exp_seq = '0;
               awaiting_first = 1'b1;
               fin_seq = '0;
               wait_count = '0;
               held_n = 0;
               history_n = 0;
               phase = PH_SYN;
               add_send(T_SYN, init_seq, '0);
            end
            OP_TICK: begin
               if (phase == PH_SYN) add_send(T_SYN, init_seq, '0);
               else if (phase == PH_NAME) add_send(T_ACK, first_seq, clip(name_len));
               else if (phase == PH_WAIT) begin
                  if (wait_count <= 1) begin
                     rsp_type c;
                     c = '0;
                     c.out_kind = KIND_CLOSED;
                     wait_count = '0;
                     phase = PH_IDLE;
                     pending.push_back(c);
                  end else begin
                     wait_count--;
                  end
               end
            end
            OP_PKT: begin
               if (phase == PH_SYN) begin
                  if (r.pkt_type == T_SYNACK) begin
                     first_seq = r.pkt_seq;
                     phase = PH_NAME;
                     add_send(T_ACK, r.pkt_seq, clip(name_len));
                  end
               end else if (phase == PH_NAME) begin
                  if (r.pkt_type == T_DATA) begin
                     phase = PH_CONN;
                     accept_data(r);
                  end else begin
                     acknowledge(r.pkt_seq);
                  end
               end else if (phase == PH_CONN) begin
                  if (r.pkt_type == T_FIN) begin
                     fin_seq = r.pkt_seq;
                     wait_count = wait_ticks;
                     phase = PH_WAIT;
                     add_send(T_FIN, r.pkt_seq, '0);
                  end else if (r.pkt_type == T_DATA) begin
                     accept_data(r);
                  end
               end else if (phase == PH_WAIT) begin
                  add_send(T_FIN, fin_seq, '0);
               end
            end
            default: ;
         endcase
         if (pending.size() > prior_size) pending[pending.size() - 1].last = 1'b1;
      endfunction

      function void check_result(rsp_type a, time t);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", t, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.out_kind !== e.out_kind || a.send_type !== e.send_type ||
             a.send_seq !== e.send_seq || a.send_length !== e.send_length ||
             a.deliver_slot !== e.deliver_slot || a.deliver_length !== e.deliver_length ||
             a.overflow !== e.overflow || a.last !== e.last) begin
            $display("%0t: mismatch expected %h actual %h", t, e, a);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;

   rx_scoreboard sb = new();
   int           item_count = 0;
   int           idle_pct = 26;
   logic [3:0]   cur_wait = 4'd2;
   bit           flooded = 0;
   bit           flood_now = 0;

   reliable_udp_receive_reorder_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data, $time);
   end

   function automatic req_type mk(logic [1:0] op, logic [2:0] t, logic [14:0] s,
                                  logic [14:0] n, logic [9:0] l, logic [9:0] slot);
      req_type r;
      r.op = op;
      r.pkt_type = t;
      r.pkt_seq = s;
      r.pkt_next_seq = n;
      r.pkt_length = l;
      r.payload_slot = slot;
      return r;
   endfunction

   task automatic put_item(req_type r);
      start <= 1'b1;
      req_data <= r;
      do @(negedge clock); while (busy);
      sb.note_request(r);
      @(posedge clock);
      item_count++;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      while (busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [14:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, val);
      if (idx == CSR_TIME_WAIT_TICKS) cur_wait = val[3:0];
   endtask

   task automatic tick();
      put_item(mk(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom));
   endtask

   task automatic close_out();
      put_item(mk(OP_PKT, T_FIN, $urandom, $urandom, $urandom, $urandom));
      if ($urandom_range(1)) put_item(mk(OP_PKT, $urandom, $urandom, $urandom, $urandom,
                                         $urandom));
      repeat ((cur_wait == 0 ? 1 : cur_wait) + $urandom_range(1)) tick();
   endtask

   task automatic session(int ndata, bit flood);
      logic [14:0] s0, seqs[$], nxts[$];
      logic [14:0] s, tmp;
      int          k, j, step;
      put_item(mk(OP_OPEN, $urandom, $urandom, $urandom, $urandom, $urandom));
      repeat ($urandom_range(2)) tick();
      if ($urandom_range(3) == 0) put_item(mk(OP_PKT, T_ACK, $urandom, 0, 0, 0));
      s0 = $urandom;
      put_item(mk(OP_PKT, T_SYNACK, s0, $urandom, $urandom, $urandom));
      repeat ($urandom_range(1)) tick();
      if ($urandom_range(3) == 0) put_item(mk(OP_PKT, T_SYN, $urandom, 0, 0, 0));
      s = s0;
      for (k = 0; k < ndata; k++) begin
         step = flood ? 10 : $urandom_range(1, 1010);
         seqs.push_back(s);
         nxts.push_back(s + step[14:0]);
         s = s + step[14:0];
      end
      if (flood) begin
         for (k = 1; k < ndata; k++)
            put_item(mk(OP_PKT, T_DATA, seqs[k], nxts[k], $urandom, $urandom));
         put_item(mk(OP_PKT, T_DATA, seqs[0], nxts[0], $urandom, $urandom));
      end else begin
         for (k = 0; k < ndata - 1; k++) begin
            if ($urandom_range(2) == 0) begin
               j = k + $urandom_range(1, 3);
               if (j >= ndata) j = ndata - 1;
               tmp = seqs[k]; seqs[k] = seqs[j]; seqs[j] = tmp;
               tmp = nxts[k]; nxts[k] = nxts[j]; nxts[j] = tmp;
            end
         end
         for (k = 0; k < ndata; k++) begin
            put_item(mk(OP_PKT, T_DATA, seqs[k], nxts[k], $urandom, $urandom));
            if ($urandom_range(9) == 0) begin
               j = $urandom_range(k);
               put_item(mk(OP_PKT, T_DATA, seqs[j], nxts[j], $urandom, $urandom));
            end
            if ($urandom_range(9) == 0) tick();
            if ($urandom_range(14) == 0)
               put_item(mk(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom));
         end
      end
      close_out();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put_item(mk(OP_TICK, T_NONE, 0, 0, 0, 0));
      put_item(mk(OP_PKT, T_SYNACK, 1, 0, 0, 0));
      put_item(mk(2'd3, 3'd7, 15'h7FFF, 15'h7FFF, 10'h3FF, 10'h3FF));
      settle();
      write_csr(CSR_INITIAL_SEQ, 15'd30719);
      write_csr(CSR_NAME_LENGTH, 15'd1023);
      write_csr(CSR_TIME_WAIT_TICKS, 15'd0);
      put_item(mk(OP_OPEN, T_NONE, 0, 0, 0, 0));
      put_item(mk(OP_OPEN, T_NONE, 0, 0, 0, 0));
      tick();
      put_item(mk(OP_PKT, T_ACK, 5, 0, 0, 0));
      put_item(mk(OP_PKT, T_SYNACK, 15'h7FFF, 0, 0, 0));
      tick();
      put_item(mk(OP_PKT, T_FIN, 15'h1234, 0, 0, 0));
      put_item(mk(OP_PKT, T_DATA, 15'd9, 15'd20, 10'd0, 10'd0));
      put_item(mk(OP_PKT, T_DATA, 15'h7FFF, 15'd9, 10'h3FF, 10'h3FF));
      put_item(mk(OP_PKT, T_DATA, 15'h7FFF, 15'd9, 10'd1010, 10'd7));
      tick();
      put_item(mk(OP_PKT, T_SYN, 15'd3, 0, 0, 0));
      put_item(mk(OP_PKT, T_DATA, 15'd20, 15'd0, 10'd1011, 10'h155));
      put_item(mk(OP_PKT, T_FIN, 15'h2AAA, 0, 0, 0));
      put_item(mk(OP_PKT, T_DATA, 15'd1, 15'd2, 10'd3, 10'd4));
      tick();
      tick();
      settle();

      while (item_count < 135) begin
         idle_pct = (item_count < 60) ? 26 : (item_count < 100) ? 47 : 0;
         case ($urandom_range(3))
            0: begin
               write_csr(CSR_INITIAL_SEQ, 15'd0);
               write_csr(CSR_NAME_LENGTH, 15'd0);
               write_csr(CSR_TIME_WAIT_TICKS, 15'd15);
            end
            1: begin
               write_csr(CSR_INITIAL_SEQ, $urandom_range(30719));
               write_csr(CSR_NAME_LENGTH, $urandom_range(1010));
               write_csr(CSR_TIME_WAIT_TICKS, $urandom_range(1, 15));
            end
            2: write_csr(CSR_TIME_WAIT_TICKS, 15'd1);
            default: ;
         endcase
         flood_now = !flooded && (item_count > 60);
         if (flood_now) flooded = 1;
         session(flood_now ? 36 : $urandom_range(3, 14), flood_now);
         settle();
      end

      settle();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("testbench: done, errors");
      $finish;
   end
endmodule
